>>> rtl/usb_midi_sysex_depacketizer_top_macros.svh
// Assertion macros for the USB-MIDI SysEx depacketizer.
// Included by the top level; depends on nothing else.
`ifndef USB_MIDI_SYSEX_DEPACKETIZER_TOP_MACROS_SVH
`define USB_MIDI_SYSEX_DEPACKETIZER_TOP_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define UMSD_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define UMSD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/umsd_pkg.sv
// Shared types and constants of the USB-MIDI SysEx depacketizer.
// Used by the front end, the command queue, the back end and the top level.
package umsd_pkg;

	// Code index numbers of the SysEx event packets.
	localparam logic [3:0] CIN_SYSEX_CONT = 4'h4;
	localparam logic [3:0] CIN_SYSEX_END1 = 4'h5;
	localparam logic [3:0] CIN_SYSEX_END2 = 4'h6;
	localparam logic [3:0] CIN_SYSEX_END3 = 4'h7;

	// SysEx framing bytes.
	localparam logic [7:0] SYSEX_START = 8'hF0;
	localparam logic [7:0] SYSEX_END   = 8'hF7;

	// Configuration register indexes.
	localparam logic CFG_CABLE_NUMBER    = 1'b0;
	localparam logic CFG_MANUFACTURER_ID = 1'b1;

	// Configuration reset values.
	localparam logic [3:0]  CABLE_RESET = 4'd1;
	localparam logic [23:0] MFR_RESET   = 24'h002033;

	// Message position limit: the position saturates here.
	localparam int MAX_MESSAGE_BYTES = 1024;
	localparam logic [9:0] POS_LIMIT =
		(MAX_MESSAGE_BYTES - 1 > 1023) ? 10'd1023 : 10'(MAX_MESSAGE_BYTES - 1);

	// One decoded event word, as handed from the front end to the back end.
	// For a SysEx word, bytes[0..last_idx] are emitted in order; the last one
	// closes the message when has_end is set.
	typedef struct packed {
		logic            is_pass;
		logic [31:0]     word;
		logic [2:0][7:0] bytes;
		logic [1:0]      last_idx;
		logic            has_end;
		logic            ferr;
	} cmd_t;

	// Fill status of the command queue.
	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

>>> rtl/umsd_event_if.sv
// Input channel of the depacketizer: one USB-MIDI event word per transaction.
// Depends on nothing.
interface umsd_event_if;
	logic        valid;
	logic        ready;
	logic [31:0] event_word;

	modport source (output valid, output event_word, input ready);
	modport sink (input valid, input event_word, output ready);
endinterface

>>> rtl/umsd_result_if.sv
// Output channel of the depacketizer: one rebuilt byte or passed word per transaction.
// Depends on nothing.
interface umsd_result_if;
	logic        valid;
	logic        ready;
	logic        result_kind;
	logic [7:0]  data_byte;
	logic [9:0]  byte_index;
	logic        end_of_message;
	logic        header_mismatch;
	logic        framing_error;
	logic [31:0] passed_word;
	logic        last_of_run;

	modport source (output valid, output result_kind, output data_byte,
		output byte_index, output end_of_message, output header_mismatch,
		output framing_error, output passed_word, output last_of_run, input ready);
	modport sink (input valid, input result_kind, input data_byte,
		input byte_index, input end_of_message, input header_mismatch,
		input framing_error, input passed_word, input last_of_run, output ready);
endinterface

>>> rtl/umsd_front.sv
// Front end: accepts event words and decodes each into a byte command.
// Depends on umsd_pkg and umsd_event_if.
module umsd_front
	import umsd_pkg::*;
(
	umsd_event_if.sink pkt,
	input  logic [3:0] cable_number,
	input  q_status_t  q_status,
	output logic       push,
	output cmd_t       cmd
);

	logic [3:0] cable;
	logic [3:0] cin;
	logic [7:0] b1;
	logic [7:0] b2;
	logic [7:0] b3;

	assign cable = pkt.event_word[31:28];
	assign cin   = pkt.event_word[27:24];
	assign b1    = pkt.event_word[23:16];
	assign b2    = pkt.event_word[15:8];
	assign b3    = pkt.event_word[7:0];

	// A word is taken whenever the queue has room.
	assign pkt.ready = !q_status.full;
	assign push      = pkt.valid && !q_status.full;

	// Decode the cable and code index into the bytes to emit and the closing flags, or mark the word for pass-through.
	always_comb begin
		cmd          = '0;
		cmd.word     = pkt.event_word;
		cmd.is_pass  = 1'b0;
		if (cable != cable_number) begin
			cmd.is_pass = 1'b1;
		end else begin
			case (cin)
				CIN_SYSEX_CONT: begin
					cmd.bytes    = {b3, b2, b1};
					cmd.last_idx = 2'd2;
				end
				CIN_SYSEX_END1: begin
					cmd.bytes[0] = SYSEX_END;
					cmd.last_idx = 2'd0;
					cmd.has_end  = 1'b1;
					cmd.ferr     = (b1 != SYSEX_END);
				end
				CIN_SYSEX_END2: begin
					cmd.has_end = 1'b1;
					if (b1 == SYSEX_END) begin
						cmd.bytes[0] = SYSEX_END;
						cmd.last_idx = 2'd0;
					end else begin
						cmd.bytes[0] = b1;
						cmd.bytes[1] = SYSEX_END;
						cmd.last_idx = 2'd1;
						cmd.ferr     = (b2 != SYSEX_END);
					end
				end
				CIN_SYSEX_END3: begin
					cmd.has_end = 1'b1;
					if (b1 == SYSEX_END) begin
						cmd.bytes[0] = SYSEX_END;
						cmd.last_idx = 2'd0;
					end else if (b2 == SYSEX_END) begin
						cmd.bytes[0] = b1;
						cmd.bytes[1] = SYSEX_END;
						cmd.last_idx = 2'd1;
					end else begin
						cmd.bytes    = {SYSEX_END, b2, b1};
						cmd.last_idx = 2'd2;
						cmd.ferr     = (b3 != SYSEX_END);
					end
				end
				default: begin
					cmd.is_pass = 1'b1;
				end
			endcase
		end
	end

endmodule

>>> rtl/umsd_queue.sv
// Short command queue between the front end and the back end.
// Depends on umsd_pkg.
module umsd_queue
	import umsd_pkg::*;
#(
	parameter int DEPTH = 2
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  cmd_t      push_cmd,
	input  logic      pop,
	output cmd_t      head,
	output q_status_t status
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	cmd_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign status.full  = (count_q == CNT_W'(DEPTH));
	assign status.empty = (count_q == '0);
	assign head         = mem_q[rd_ptr_q];

	// Entry storage; entries are read only after they are written.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Pointers wrap at the depth, which need not be a power of two.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> rtl/umsd_back.sv
// Back end: walks each queued command one result per cycle while not stalled,
// tracks the message position and checks the header. Depends on umsd_pkg and umsd_result_if.
module umsd_back
	import umsd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic [23:0] manufacturer_id,
	input  cmd_t        head,
	input  q_status_t   q_status,
	output logic        pop,
	umsd_result_if.source res
);

	logic [1:0] sel_q;
	logic [9:0] pos_q;
	logic       out_valid_q;

	logic       load;
	logic       is_last;
	logic       is_end;
	logic [7:0] cur_byte;
	logic [7:0] expected;

	// The output register takes a new result when the queue holds a command and it is empty or being drained.
	assign load     = !q_status.empty && (!out_valid_q || res.ready);
	assign is_last  = head.is_pass || (sel_q == head.last_idx);
	assign is_end   = head.has_end && is_last && !head.is_pass;
	assign pop      = load && is_last;
	assign cur_byte = head.bytes[sel_q];

	// Expected header byte at positions zero to three.
	always_comb begin
		case (pos_q[1:0])
			2'd0:    expected = SYSEX_START;
			2'd1:    expected = manufacturer_id[23:16];
			2'd2:    expected = manufacturer_id[15:8];
			default: expected = manufacturer_id[7:0];
		endcase
	end

	// Byte selector and message position.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q       <= '0;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				sel_q       <= is_last ? 2'd0 : sel_q + 2'd1;
				if (!head.is_pass) begin
					if (is_end) begin
						pos_q <= '0;
					end else if (pos_q < POS_LIMIT) begin
						pos_q <= pos_q + 10'd1;
					end
				end
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Output payload register.
	always_ff @(posedge clk) begin
		if (load) begin
			res.result_kind     <= head.is_pass;
			res.last_of_run     <= is_last;
			res.passed_word     <= head.is_pass ? head.word : 32'd0;
			res.data_byte       <= head.is_pass ? 8'd0 : cur_byte;
			res.byte_index      <= head.is_pass ? 10'd0 : pos_q;
			res.end_of_message  <= is_end;
			res.framing_error   <= is_end && head.ferr;
			res.header_mismatch <= !head.is_pass && (pos_q <= 10'd3) && (cur_byte != expected);
		end
	end

	assign res.valid = out_valid_q;

endmodule

>>> rtl/usb_midi_sysex_depacketizer_top.sv
// Top level of the USB-MIDI SysEx depacketizer: configuration registers,
// front end, command queue and back end. Depends on umsd_pkg, both channel
// interfaces, umsd_front, umsd_queue, umsd_back and the assertion macros.
//
//  Channel  Direction  Moves per transaction
//  pkt      in         one 32-bit USB-MIDI event word
//  result   out        one SysEx byte with its tags, or one passed-through word
//  cfg_*    in         one register write (index 0 cable, 1 manufacturer ID)
//
// A word is accepted in any cycle in which the command queue has room.
// The back end emits one result per cycle while its output is not stalled, so a
// word yields one to three results there: three for a continuation word.
// An accepted word is held in the command queue, then its results in the output register.
// Reset clears control state only; a stalled output holds its result and the
// queue keeps taking words until full.
`include "usb_midi_sysex_depacketizer_top_macros.svh"

module usb_midi_sysex_depacketizer_top
	import umsd_pkg::*;
#(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	umsd_event_if.sink  pkt,
	umsd_result_if.source result,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [23:0] cfg_wdata
);

	logic [3:0]  cable_q;
	logic [23:0] mfr_q;
	logic        push;
	logic        pop;
	cmd_t        push_cmd;
	cmd_t        head;
	q_status_t   q_status;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cable_q <= CABLE_RESET;
			mfr_q   <= MFR_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_CABLE_NUMBER:    cable_q <= cfg_wdata[3:0];
				CFG_MANUFACTURER_ID: mfr_q   <= cfg_wdata;
				default:             cable_q <= cable_q;
			endcase
		end
	end

	umsd_front u_front (
		.pkt          (pkt),
		.cable_number (cable_q),
		.q_status     (q_status),
		.push         (push),
		.cmd          (push_cmd)
	);

	umsd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.status   (q_status)
	);

	umsd_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.manufacturer_id (mfr_q),
		.head            (head),
		.q_status        (q_status),
		.pop             (pop),
		.res             (result)
	);

	// A framing error is only ever reported on the closing byte.
	`UMSD_ASSERT_SAME(a_ferr_on_end, clk, arst_n, result.valid && result.framing_error, result.end_of_message, "framing error without end of message")
	// The closing byte is always the final result of its word.
	`UMSD_ASSERT_SAME(a_end_is_last, clk, arst_n, result.valid && result.end_of_message, result.last_of_run, "end of message not last of run")
	// Header checks apply to the first four positions only.
	`UMSD_ASSERT_SAME(a_hdr_pos, clk, arst_n, result.valid && result.header_mismatch, result.byte_index <= 10'd3 && !result.result_kind, "header mismatch outside header")
	// An accepted word leaves the queue non-empty until the back end takes it.
	`UMSD_ASSERT_NEXT(a_push_fills, clk, arst_n, pkt.valid && pkt.ready, !q_status.empty, "queue empty after accepted word")

endmodule
